// ----- rtl/bs3_pkg.sv -----
// bs3_pkg: shared constants, types and status structs for the 3x3 box-sum core
// depends on nothing; imported by bs3_pos, bs3_sum and box_sum_3x3_valid_core
package bs3_pkg;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned KERNEL        = 3;
  localparam int unsigned COL_BITS      = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_BITS      = 11;
  localparam int unsigned WIDTH_RESET   = 1024;
  localparam int unsigned CSUM_BITS     = SAMPLE_BITS + 2;
  localparam int unsigned SUM_BITS      = SAMPLE_BITS + 4;
  localparam int unsigned IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = ((SUM_BITS + 7) / 8) * 8;

  typedef logic [COL_BITS-1:0]                col_t;
  typedef logic [CFG_BITS-1:0]                lwidth_t;
  typedef logic signed [SAMPLE_BITS-1:0]      sample_t;
  typedef logic signed [CSUM_BITS-1:0]        csum_t;
  typedef logic signed [SUM_BITS-1:0]         wsum_t;

  // position of the word just accepted
  typedef struct packed {
    col_t col;
    logic emit;
    logic last;
  } pos_t;

  // occupancy of the read-data stage
  typedef struct packed {
    logic valid;
    logic fire;
    logic emit;
  } s1_stat_t;

  // one finished result
  typedef struct packed {
    wsum_t window_sum;
    logic  row_end;
  } res_t;

endpackage

// ----- rtl/bs3_ram.sv -----
// bs3_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing; no reset on the storage
module bs3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bs3_pos.sv -----
// bs3_pos: line width register and column/row position tracking
// depends on bs3_pkg
module bs3_pos (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  bs3_pkg::lwidth_t  cfg_data_i,
  input  logic              acc_i,
  input  logic              frame_start_i,
  output bs3_pkg::pos_t     pos_o
);
  import bs3_pkg::*;

  lwidth_t    width_q;
  lwidth_t    width_eff;
  lwidth_t    col_inc;
  col_t       col_q, col_d, col_cur;
  logic [1:0] row_q, row_d, row_cur;
  logic       last;

  // effective width saturates at the buffer depth
  always_comb begin
    width_eff = (width_q > lwidth_t'(MAX_WIDTH)) ? lwidth_t'(MAX_WIDTH) : width_q;
    col_cur   = frame_start_i ? '0 : col_q;
    row_cur   = frame_start_i ? '0 : row_q;
    col_inc   = lwidth_t'(col_cur) + lwidth_t'(1);
    last      = (col_inc >= width_eff);
  end

  // next position after this word
  always_comb begin
    if (last) begin
      col_d = '0;
      row_d = (row_cur < 2'(KERNEL - 1)) ? row_cur + 2'd1 : row_cur;
    end else begin
      col_d = col_inc[COL_BITS-1:0];
      row_d = row_cur;
    end
  end

  assign pos_o.col  = col_cur;
  assign pos_o.last = last;
  assign pos_o.emit = (width_eff >= lwidth_t'(KERNEL)) && (row_cur >= 2'(KERNEL - 1)) &&
                      (col_cur >= col_t'(KERNEL - 1));

  // width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= lwidth_t'(WIDTH_RESET);
    end else if (cfg_we_i) begin
      width_q <= cfg_data_i;
    end
  end

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- rtl/bs3_sum.sv -----
// bs3_sum: line buffers, read-data stage, column sums and window total
// depends on bs3_pkg and bs3_ram
module bs3_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  bs3_pkg::sample_t    sample_i,
  input  bs3_pkg::pos_t       pos_i,
  input  logic                out_free_i,
  output bs3_pkg::s1_stat_t   stat_o,
  output bs3_pkg::res_t       res_o
);
  import bs3_pkg::*;

  logic    s1_valid_q;
  sample_t s1_sample_q;
  col_t    s1_col_q;
  logic    s1_emit_q, s1_last_q;
  logic    byp_q;
  sample_t byp_above_q, byp_two_q;
  csum_t   win0_q, win1_q;
  logic    fire;
  logic [SAMPLE_BITS-1:0] above_rd, two_rd;
  sample_t above, two_above;
  csum_t   col_sum;
  wsum_t   total;

  // previous row and the row before it
  bs3_ram #(.Width(SAMPLE_BITS), .Depth(MAX_WIDTH)) u_line_above (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_sample_q),
    .re_i    (acc_i),
    .raddr_i (pos_i.col),
    .rdata_o (above_rd)
  );

  bs3_ram #(.Width(SAMPLE_BITS), .Depth(MAX_WIDTH)) u_line_two_above (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (s1_col_q),
    .wdata_i (above),
    .re_i    (acc_i),
    .raddr_i (pos_i.col),
    .rdata_o (two_rd)
  );

  // stage leaves when it has no result or the output register can take it
  assign fire = s1_valid_q && (!s1_emit_q || out_free_i);

  // forward a write that lands on the same edge as the read of that column
  always_comb begin
    above     = byp_q ? byp_above_q : $signed(above_rd);
    two_above = byp_q ? byp_two_q   : $signed(two_rd);
    col_sum   = csum_t'(s1_sample_q) + csum_t'(above) + csum_t'(two_above);
    total     = wsum_t'(col_sum) + wsum_t'(win0_q) + wsum_t'(win1_q);
  end

  assign stat_o.valid     = s1_valid_q;
  assign stat_o.fire      = fire;
  assign stat_o.emit      = s1_emit_q;
  assign res_o.window_sum = total;
  assign res_o.row_end    = s1_last_q;

  // stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (acc_i) begin
      s1_valid_q <= 1'b1;
      byp_q      <= fire && (s1_col_q == pos_i.col);
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage payload and forwarded words
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= pos_i.col;
      s1_emit_q   <= pos_i.emit;
      s1_last_q   <= pos_i.last;
      byp_above_q <= s1_sample_q;
      byp_two_q   <= above;
    end
  end

  // column sums of the two previous columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (fire) begin
      win1_q <= win0_q;
      win0_q <= col_sum;
    end
  end

endmodule

// ----- rtl/box_sum_3x3_valid_core.sv -----
// box_sum_3x3_valid_core: streaming 3x3 box sum over valid windows only
// depends on bs3_pkg, bs3_pos, bs3_sum, bs3_ram
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata sample_value, tuser frame_start
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata window_sum, tlast row_end
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i line_width
//
// one word per clock unless stalled; a taken word reaches the output through
// the ram read stage, then the output register; the ram read port sets that depth.
// reset clears positions, column sums and the width register (1024); line
// buffers are not cleared. the input stalls only while the read stage holds a
// result that the full output register cannot take.
module box_sum_3x3_valid_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bs3_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,   // [15:0] sample_value
  input  logic                                s_axis_tuser,   // [0] frame_start
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bs3_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,   // [19:0] window_sum, rest zero
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  bs3_pkg::lwidth_t                    cfg_data_i
);
  import bs3_pkg::*;

  pos_t     pos;
  s1_stat_t stat;
  res_t     res;
  logic     acc, out_free, load;
  logic     out_valid_q;
  wsum_t    out_sum_q;
  logic     out_last_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !stat.valid || stat.fire;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load          = stat.fire && stat.emit;

  bs3_pos u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .acc_i         (acc),
    .frame_start_i (s_axis_tuser),
    .pos_o         (pos)
  );

  bs3_sum u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .sample_i   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .pos_i      (pos),
    .out_free_i (out_free),
    .stat_o     (stat),
    .res_o      (res)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sum_q  <= res.window_sum;
      out_last_q <= res.row_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'($unsigned(out_sum_q));
  assign m_axis_tlast  = out_last_q;

  // a new result always comes out of the read stage
  a_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stat.valid))
    else $error("result word without a filled read stage");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(stat.fire && stat.emit))
    else $error("output register overwritten while stalled");

  // a held read stage blocks the input
  a_stage_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.valid && !stat.fire) |-> !s_axis_tready)
    else $error("input taken while read stage is held");

endmodule
